// ----- rtl/bfp_pkg.sv -----
package bfp_pkg;

   // Action codes carried in the action field of an input item.
   typedef enum logic [2:0] {
      ACT_ENQUEUE = 3'd0,
      ACT_DEQUEUE = 3'd1,
      ACT_PEEK    = 3'd2,
      ACT_COMMIT  = 3'd3,
      ACT_REWIND  = 3'd4
   } bfp_action_type;

   localparam int unsigned SIZE_WIDTH = 9;
   localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 9'd256;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] data_in;
   } bfp_req_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] data_out;
      logic       is_empty;
      logic       is_full;
   } bfp_rsp_type;

   // Outcome of one action, passed from the cursor logic to the output pipeline.
   // The read flag says that data_out comes from the buffer read.
   typedef struct packed {
      logic ok;
      logic read;
      logic is_empty;
      logic is_full;
   } bfp_status_type;

endpackage

// ----- rtl/byte_fifo_with_peek.sv -----
//  Channel   Direction  Handshake            Carries
//  req_      in         req_valid/req_stall  bfp_req_type item (action, data_in)
//  rsp_      out        rsp_valid/rsp_stall  bfp_rsp_type item (ok, data_out, flags)
//  csr_      in         csr_valid/csr_ready  size_in_use, 9 bits
//
//  One item is taken per cycle while the result side keeps up. The buffer
//  memory read and the middle stage load when an item is accepted, and the
//  result register loads from the middle stage when that stage moves on,
//  which waits while rsp_stall holds a result in the result register.
//  Reset clears the cursors, the counts and the valid flags and sets the size
//  to 256; no memory clearing is done. When rsp_stall holds a result, one more
//  item is still taken into the middle stage, then req_stall rises.
module byte_fifo_with_peek import bfp_pkg::*; #(
   parameter int unsigned DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bfp_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bfp_rsp_type           rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_WIDTH-1:0] csr_data
);

   localparam int unsigned AW = $clog2(DEPTH);

   // Configuration: the size register is always ready for a write.
   logic [SIZE_WIDTH-1:0] size_ff;

   // Middle stage: the outcome of an accepted item waits here next to the
   // memory read data that belongs to it.
   logic                  mid_valid_ff;
   bfp_status_type        mid_status_ff;
   logic                  mid_move;

   // Result register.
   logic                  rsp_valid_ff;
   bfp_rsp_type           rsp_data_ff;

   logic                  item_take;
   bfp_status_type        status;
   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [7:0]            wr_data;
   logic [7:0]            rd_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   // The middle stage moves on whenever the result register is free or
   // is being emptied this cycle; a new item may enter behind it then.
   assign mid_move  = mid_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = mid_valid_ff && !mid_move;
   assign item_take = req_valid && !req_stall;

   bfp_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_take   (item_take),
      .action      (req_data.action),
      .data_in     (req_data.data_in),
      .size_in_use (size_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .status      (status)
   );

   // The byte buffer. Its read register only loads on an accepted read, so it
   // stays aligned with the middle stage while that stage waits.
   bfp_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (item_take) begin
         mid_valid_ff <= 1'b1;
      end else if (mid_move) begin
         mid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         mid_status_ff <= status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mid_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Actions that read nothing report a zero byte.
   always_ff @(posedge clock) begin
      if (mid_move) begin
         rsp_data_ff.ok       <= mid_status_ff.ok;
         rsp_data_ff.data_out <= mid_status_ff.read ? rd_data_ff : 8'd0;
         rsp_data_ff.is_empty <= mid_status_ff.is_empty;
         rsp_data_ff.is_full  <= mid_status_ff.is_full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/bfp_store.sv -----
module bfp_store import bfp_pkg::*; #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read data register holds its value until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/bfp_ctrl.sv -----
module bfp_ctrl import bfp_pkg::*; #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_take,
   input  logic [2:0]            action,
   input  logic [7:0]            data_in,
   input  logic [SIZE_WIDTH-1:0] size_in_use,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [7:0]            wr_data,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   output bfp_status_type        status
);

   // Counts must hold both DEPTH and the largest register value.
   localparam int unsigned CW = ((AW + 1) > SIZE_WIDTH) ? (AW + 1) : SIZE_WIDTH;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] peek_ff, peek_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] prem_ff, prem_in;

   logic [CW-1:0] size_ext;
   logic [CW-1:0] eff_size;
   logic [AW-1:0] head_adv, tail_adv, peek_adv;
   logic          do_write, do_read, ok;
   logic [AW-1:0] read_addr;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx,
                                             input logic [CW-1:0] lim);
      logic [CW-1:0] nxt;
      nxt = CW'(idx) + CW'(1);
      return (nxt >= lim) ? '0 : nxt[AW-1:0];
   endfunction

   // A size of zero counts as one, anything beyond the buffer as the buffer.
   assign size_ext = CW'(size_in_use);
   always_comb begin
      if (size_ext == '0) begin
         eff_size = CW'(1);
      end else if (size_ext > CW'(DEPTH)) begin
         eff_size = CW'(DEPTH);
      end else begin
         eff_size = size_ext;
      end
   end

   assign head_adv = advance(head_ff, eff_size);
   assign tail_adv = advance(tail_ff, eff_size);
   assign peek_adv = advance(peek_ff, eff_size);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      peek_in   = peek_ff;
      count_in  = count_ff;
      prem_in   = prem_ff;
      do_write  = 1'b0;
      do_read   = 1'b0;
      read_addr = head_ff;
      ok        = 1'b0;
      case (bfp_action_type'(action))
         ACT_ENQUEUE: begin
            if (count_ff < eff_size) begin
               do_write = 1'b1;
               tail_in  = tail_adv;
               count_in = count_ff + CW'(1);
               prem_in  = prem_ff + CW'(1);
               ok       = 1'b1;
            end
         end
         ACT_DEQUEUE: begin
            if (count_ff != '0) begin
               do_read   = 1'b1;
               read_addr = head_ff;
               head_in   = head_adv;
               count_in  = count_ff - CW'(1);
               peek_in   = head_adv;
               prem_in   = count_ff - CW'(1);
               ok        = 1'b1;
            end
         end
         ACT_PEEK: begin
            if (prem_ff != '0) begin
               do_read   = 1'b1;
               read_addr = peek_ff;
               peek_in   = peek_adv;
               prem_in   = prem_ff - CW'(1);
               ok        = 1'b1;
            end
         end
         ACT_COMMIT: begin
            head_in  = peek_ff;
            count_in = prem_ff;
            ok       = 1'b1;
         end
         ACT_REWIND: begin
            peek_in = head_ff;
            prem_in = count_ff;
            ok      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign wr_en   = item_take && do_write;
   assign wr_addr = tail_ff;
   assign wr_data = data_in;
   assign rd_en   = item_take && do_read;
   assign rd_addr = read_addr;

   always_comb begin
      status.ok       = ok;
      status.read     = do_read;
      status.is_empty = (count_in == '0);
      status.is_full  = (count_in >= eff_size);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         peek_ff  <= '0;
         count_ff <= '0;
         prem_ff  <= '0;
      end else if (item_take) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         peek_ff  <= peek_in;
         count_ff <= count_in;
         prem_ff  <= prem_in;
      end
   end

endmodule
